FILE: rtl/frustum_aabb_cull_macros.svh
// ---------------------------------------------------------------------------
// Frustum box culler assertion macros
// Shared concurrent assertion shorthands for the culler RTL.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_AABB_CULL_MACROS_SVH
`define FRUSTUM_AABB_CULL_MACROS_SVH

// same-cycle implication, disabled in reset
`define FAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fac_pkg.sv
// ---------------------------------------------------------------------------
// Frustum box culler package
// Widths, plane and box types, and stage control shared by the culler RTL.
// ---------------------------------------------------------------------------
package fac_pkg;

  localparam int COORD_WIDTH  = 32;                 // used bits of each coordinate
  localparam int FIELD_W      = 32;                 // coordinate port width
  localparam int ELEM_W       = 32;                 // matrix element, Q16.16
  localparam int PLANE_W      = ELEM_W + 1;         // plane coefficient, Q17.16
  localparam int FRAC_BITS    = 16;
  localparam int OFFS_W       = PLANE_W + FRAC_BITS;
  localparam int PROD_W       = PLANE_W + COORD_WIDTH;
  localparam int PSUM_W       = PROD_W + 1;
  localparam int SUM_W        = PROD_W + 2;
  localparam int NUM_PLANES   = 6;
  localparam int NUM_ROWS     = 3;
  localparam int NUM_ELEMS    = 16;
  localparam int NUM_CFG_REGS = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 2 * ELEM_W;

  typedef logic signed [ELEM_W-1:0]      elem_t;
  typedef logic signed [PLANE_W-1:0]     coef_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    coef_t d;
  } plane_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_t;

  typedef struct packed {
    logic s2_load;
    logic s3_load;
  } stage_en_t;

  // keep the low COORD_WIDTH bits, read as signed
  function automatic coord_t coord_trim(logic [FIELD_W-1:0] v);
    return $signed(v[COORD_WIDTH-1:0]);
  endfunction

endpackage

FILE: rtl/fac_ifs.sv
// ---------------------------------------------------------------------------
// Frustum box culler channels
// Valid/ready channels for box items and visibility result items.
// ---------------------------------------------------------------------------
interface fac_box_if;
  logic                                valid;
  logic                                ready;
  logic signed [fac_pkg::FIELD_W-1:0]  min_x;
  logic signed [fac_pkg::FIELD_W-1:0]  min_y;
  logic signed [fac_pkg::FIELD_W-1:0]  min_z;
  logic signed [fac_pkg::FIELD_W-1:0]  max_x;
  logic signed [fac_pkg::FIELD_W-1:0]  max_y;
  logic signed [fac_pkg::FIELD_W-1:0]  max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface fac_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

FILE: rtl/fac_plane_eval.sv
// ---------------------------------------------------------------------------
// Frustum box culler plane evaluator
// Positive-vertex dot product of one plane over two register stages;
// flags a negative exact sum.
// ---------------------------------------------------------------------------
module fac_plane_eval (
  input  logic               clk,
  input  fac_pkg::plane_t    plane,
  input  fac_pkg::box_t      box,
  input  fac_pkg::stage_en_t en,
  output logic               neg
);
  import fac_pkg::*;

  coord_t                     vx, vy, vz;
  logic signed [PROD_W-1:0]   prod_x_nxt, prod_y_nxt, prod_z_nxt;
  logic signed [PROD_W-1:0]   prod_x_r, prod_y_r, prod_z_r;
  logic signed [OFFS_W-1:0]   offs_nxt, offs_r;
  logic signed [PSUM_W-1:0]   psum_a_nxt, psum_b_nxt, psum_a_r, psum_b_r;
  logic signed [SUM_W-1:0]    sum;

  // pick max corner where the normal component is non-negative
  always_comb begin
    vx = plane.a[PLANE_W-1] ? box.lo_x : box.hi_x;
    vy = plane.b[PLANE_W-1] ? box.lo_y : box.hi_y;
    vz = plane.c[PLANE_W-1] ? box.lo_z : box.hi_z;
    prod_x_nxt = PROD_W'(plane.a) * PROD_W'(vx);
    prod_y_nxt = PROD_W'(plane.b) * PROD_W'(vy);
    prod_z_nxt = PROD_W'(plane.c) * PROD_W'(vz);
    offs_nxt   = $signed({plane.d, {FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en.s2_load) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      prod_z_r <= prod_z_nxt;
      offs_r   <= offs_nxt;
    end
  end

  always_comb begin
    psum_a_nxt = PSUM_W'(prod_x_r) + PSUM_W'(prod_y_r);
    psum_b_nxt = PSUM_W'(prod_z_r) + PSUM_W'(offs_r);
  end

  always_ff @(posedge clk) begin
    if (en.s3_load) begin
      psum_a_r <= psum_a_nxt;
      psum_b_r <= psum_b_nxt;
    end
  end

  always_comb begin
    sum = SUM_W'(psum_a_r) + SUM_W'(psum_b_r);
    neg = sum[SUM_W-1];
  end

endmodule

FILE: rtl/frustum_aabb_cull.sv
// ---------------------------------------------------------------------------
// Frustum box culler
// Derives six frustum planes from a column-major view-projection matrix and
// culls axis-aligned boxes whose positive vertex lies behind any plane.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake         | payload
//  in_box    | in  | valid/ready       | min_x..max_z, signed Q16.16
//  out_vis   | out | valid/ready       | visible (0 = culled)
//  cfg_*     | in  | cfg_we, no wait   | cfg_index 0..7, cfg_data m[2k], m[2k+1]
//
//  One box per cycle while the output is taken; a result is valid once its
//  item has passed the input, product, pair-sum and output registers.
//  Stages: input register, 18 multipliers (33x32), pair sums, final add and
//  plane AND into the output register. Planes are registered from the matrix
//  and follow a write in the next cycle. Reset clears the matrix: every box is
//  visible. A stall holds each full stage; empty stages still fill.
// ---------------------------------------------------------------------------
`include "frustum_aabb_cull_macros.svh"

module frustum_aabb_cull (
  input  logic                                clk,
  input  logic                                rst_n,
  fac_box_if.sink                             in_box,
  fac_vis_if.source                           out_vis,
  input  logic                                cfg_we,
  input  logic [fac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fac_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fac_pkg::*;

  elem_t                  elem_r [NUM_ELEMS];
  plane_t                 plane_nxt [NUM_PLANES];
  plane_t                 plane_r [NUM_PLANES];
  box_t                   box_r;
  logic                   s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                   s1_ready, s2_ready, s3_ready, s4_ready;
  logic                   vis_r;
  logic [NUM_PLANES-1:0]  neg;
  stage_en_t              en;

  // matrix registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < NUM_ELEMS; e++) elem_r[e] <= '0;
    end else begin
      for (int k = 0; k < NUM_CFG_REGS; k++) begin
        if (cfg_we && cfg_index == CFG_IDX_W'(k)) begin
          elem_r[2*k]   <= cfg_data[ELEM_W-1:0];
          elem_r[2*k+1] <= cfg_data[CFG_DATA_W-1:ELEM_W];
        end
      end
    end
  end

  // plane (row, side): row3 + row for side 0, row3 - row for side 1
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      plane_nxt[2*r].a   = PLANE_W'(elem_r[3])  + PLANE_W'(elem_r[r]);
      plane_nxt[2*r].b   = PLANE_W'(elem_r[7])  + PLANE_W'(elem_r[4+r]);
      plane_nxt[2*r].c   = PLANE_W'(elem_r[11]) + PLANE_W'(elem_r[8+r]);
      plane_nxt[2*r].d   = PLANE_W'(elem_r[15]) + PLANE_W'(elem_r[12+r]);
      plane_nxt[2*r+1].a = PLANE_W'(elem_r[3])  - PLANE_W'(elem_r[r]);
      plane_nxt[2*r+1].b = PLANE_W'(elem_r[7])  - PLANE_W'(elem_r[4+r]);
      plane_nxt[2*r+1].c = PLANE_W'(elem_r[11]) - PLANE_W'(elem_r[8+r]);
      plane_nxt[2*r+1].d = PLANE_W'(elem_r[15]) - PLANE_W'(elem_r[12+r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) plane_r[p] <= '0;
    end else begin
      for (int p = 0; p < NUM_PLANES; p++) plane_r[p] <= plane_nxt[p];
    end
  end

  // a stage advances when empty or when the next one advances
  always_comb begin
    s4_ready   = !s4_v_r || out_vis.ready;
    s3_ready   = !s3_v_r || s4_ready;
    s2_ready   = !s2_v_r || s3_ready;
    s1_ready   = !s1_v_r || s2_ready;
    en.s2_load = s1_v_r && s2_ready;
    en.s3_load = s2_v_r && s3_ready;
  end

  assign in_box.ready   = s1_ready;
  assign out_vis.valid  = s4_v_r;
  assign out_vis.visible = vis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_box.valid;
      if (s2_ready) s2_v_r <= s1_v_r;
      if (s3_ready) s3_v_r <= s2_v_r;
      if (s4_ready) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_box.valid && s1_ready) begin
      box_r.lo_x <= coord_trim(in_box.min_x);
      box_r.lo_y <= coord_trim(in_box.min_y);
      box_r.lo_z <= coord_trim(in_box.min_z);
      box_r.hi_x <= coord_trim(in_box.max_x);
      box_r.hi_y <= coord_trim(in_box.max_y);
      box_r.hi_z <= coord_trim(in_box.max_z);
    end
    if (s3_v_r && s4_ready) begin
      vis_r <= ~|neg;
    end
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fac_plane_eval u_eval (
      .clk   (clk),
      .plane (plane_r[p]),
      .box   (box_r),
      .en    (en),
      .neg   (neg[p])
    );
  end

  `FAC_ASSERT_IMP(a_empty_takes, clk, rst_n, !s1_v_r, in_box.ready, "empty input stage refused an item")
  `FAC_ASSERT_NEXT(a_s1_moves, clk, rst_n, s1_v_r && s2_ready, s2_v_r, "item lost between stages 1 and 2")
  `FAC_ASSERT_NEXT(a_out_drain, clk, rst_n, out_vis.valid && out_vis.ready && !s3_v_r, !out_vis.valid, "result repeated after drain")
  `FAC_ASSERT_IMP(a_planes_track, clk, rst_n, !$past(cfg_we), plane_r[0] == plane_nxt[0] && plane_r[5] == plane_nxt[5], "planes out of step with matrix")

endmodule

FILE: tb/frustum_aabb_cull_test.sv
// ---------------------------------------------------------------------------
// Frustum box culler testbench
// Loads view-projection matrices through the register port, streams boxes
// with random gaps on both channels, and checks every visibility item
// against a predictor that forms the six planes and sums the positive
// vertex exactly.
// ---------------------------------------------------------------------------
module frustum_aabb_cull_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fac_pkg::*;

  localparam int ONE               = 1 << FRAC_BITS;   // 1.0 in Q16.16
  localparam int FIRST_SPARE_INDEX = NUM_CFG_REGS;
  localparam int LAST_SPARE_INDEX  = (1 << CFG_IDX_W) - 1;
  localparam int BOXES_PER_SCENE   = 255;
  localparam int NUM_SCENES        = 6;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int DRAIN_CYCLES      = 20;

  typedef struct {
    box_t box;
    bit   visible;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fac_box_if box_ch();
  fac_vis_if vis_ch();

  elem_t    view_proj [NUM_ELEMS];
  verdict_t pending_verdicts [$];
  verdict_t head_verdict;
  int       send_gap_max = 19;
  int       take_stall_max = 19;
  int       mismatch_count = 0;
  int       quiet_cycles = 0;

  frustum_aabb_cull i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_box    (box_ch.sink),
    .out_vis   (vis_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Planes are row3 +/- row0..2; a box is culled if the positive vertex of
  // any plane lies behind it. The sum is exact in 128 bits.
  function automatic bit box_in_view(input box_t b);
    coord_t             lo [3];
    coord_t             hi [3];
    logic signed [PLANE_W-1:0] coef [4];
    logic signed [PLANE_W-1:0] r3;
    logic signed [PLANE_W-1:0] ri;
    logic signed [127:0] acc;
    logic signed [127:0] term;
    logic signed [127:0] corner;
    bit                 seen;
    seen = 1'b1;
    lo[0] = b.lo_x;
    lo[1] = b.lo_y;
    lo[2] = b.lo_z;
    hi[0] = b.hi_x;
    hi[1] = b.hi_y;
    hi[2] = b.hi_z;
    for (int row = 0; row < NUM_ROWS; row++) begin
      for (int side = 0; side < 2; side++) begin
        for (int ax = 0; ax < 4; ax++) begin
          r3 = view_proj[ax * 4 + 3];
          ri = view_proj[ax * 4 + row];
          coef[ax] = side ? r3 - ri : r3 + ri;
        end
        acc = coef[3];
        acc = acc <<< FRAC_BITS;
        for (int ax = 0; ax < 3; ax++) begin
          term = coef[ax];
          corner = (coef[ax] >= 0) ? hi[ax] : lo[ax];
          acc = acc + term * corner;
        end
        if (acc < 0) seen = 1'b0;
      end
    end
    return seen;
  endfunction

  function automatic box_t make_box(input coord_t lx, ly, lz, hx, hy, hz);
    box_t b;
    b = '{lx, ly, lz, hx, hy, hz};
    return b;
  endfunction

  // Mostly boxes near the origin, some inverted, some full range, some
  // built from extreme codes.
  function automatic box_t random_box();
    coord_t lo [3];
    coord_t hi [3];
    coord_t c;
    coord_t e;
    int     pick;
    pick = $urandom_range(9, 0);
    for (int ax = 0; ax < 3; ax++) begin
      if (pick < 6) begin
        c = $urandom_range(8 * ONE, 0) - 4 * ONE;
        e = $urandom_range(ONE, 0);
        lo[ax] = (pick == 5) ? c + e : c - e;
        hi[ax] = (pick == 5) ? c - e : c + e;
      end else if (pick < 9) begin
        lo[ax] = $urandom;
        hi[ax] = $urandom;
      end else begin
        case ($urandom_range(3, 0))
          0: lo[ax] = 32'h8000_0000;
          1: lo[ax] = 32'h7FFF_FFFF;
          2: lo[ax] = 32'h0000_0000;
          default: lo[ax] = 32'hFFFF_FFFF;
        endcase
        case ($urandom_range(3, 0))
          0: hi[ax] = 32'h8000_0000;
          1: hi[ax] = 32'h7FFF_FFFF;
          2: hi[ax] = 32'h0000_0000;
          default: hi[ax] = 32'hFFFF_FFFF;
        endcase
      end
    end
    return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx < NUM_CFG_REGS) begin
      view_proj[2 * idx] = data[ELEM_W-1:0];
      view_proj[2 * idx + 1] = data[CFG_DATA_W-1:ELEM_W];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_matrix(input elem_t m [NUM_ELEMS]);
    for (int k = 0; k < NUM_CFG_REGS; k++)
      cfg_write(CFG_IDX_W'(k), {m[2 * k + 1], m[2 * k]});
  endtask

  task automatic send_box(input box_t b);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      box_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    box_ch.valid <= 1'b1;
    box_ch.min_x <= b.lo_x;
    box_ch.min_y <= b.lo_y;
    box_ch.min_z <= b.lo_z;
    box_ch.max_x <= b.hi_x;
    box_ch.max_y <= b.hi_y;
    box_ch.max_z <= b.hi_z;
    do @(posedge clk); while (!(box_ch.valid && box_ch.ready));
    pending_verdicts.push_back('{b, box_in_view(b)});
  endtask

  // Drop valid and hold until every verdict has come back.
  task automatic wait_all_results();
    @(negedge clk);
    box_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_matrix();
    send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_box(make_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(-1, -1, -1, -1, -1, -1));
    wait_all_results();
  endtask

  task automatic test_spare_index();
    cfg_write(CFG_IDX_W'(FIRST_SPARE_INDEX), '1);
    cfg_write(CFG_IDX_W'(LAST_SPARE_INDEX), 64'h7FFF_FFFF_8000_0000);
    send_box(make_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
    send_box(make_box(32'h8000_0000, 0, 32'h7FFF_FFFF, -ONE, ONE, 0));
    wait_all_results();
  endtask

  task automatic test_identity_planes();
    elem_t m [NUM_ELEMS];
    for (int i = 0; i < NUM_ELEMS; i++) m[i] = (i % 5 == 0) ? ONE : 0;
    load_matrix(m);
    send_box(make_box(-ONE / 2, -ONE / 2, -ONE / 2, ONE / 2, ONE / 2, ONE / 2));
    send_box(make_box(2 * ONE, 0, 0, 3 * ONE, ONE / 2, ONE / 2));
    send_box(make_box(0, 0, -5 * ONE, ONE / 2, ONE / 2, -2 * ONE));
    send_box(make_box(ONE / 2, -ONE / 2, 0, 3 * ONE, ONE / 2, ONE / 2));
    // inverted boxes: corners taken as given
    send_box(make_box(ONE / 2, ONE / 2, ONE / 2, -ONE / 2, -ONE / 2, -ONE / 2));
    send_box(make_box(3 * ONE, 3 * ONE, 3 * ONE, -3 * ONE, -3 * ONE, -3 * ONE));
    wait_all_results();
  endtask

  task automatic test_zero_normal();
    elem_t m [NUM_ELEMS];
    for (int i = 0; i < NUM_ELEMS; i++) m[i] = 0;
    m[15] = -ONE;
    load_matrix(m);
    send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_box(make_box(0, 0, 0, ONE, ONE, ONE));
    wait_all_results();
  endtask

  task automatic test_extreme_matrix();
    elem_t m [NUM_ELEMS];
    for (int pass = 0; pass < 3; pass++) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
        case (pass)
          0: m[i] = 32'h8000_0000;
          1: m[i] = 32'h7FFF_FFFF;
          default: m[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
      end
      load_matrix(m);
      send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_box(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      wait_all_results();
    end
  endtask

  // Scene kinds: scaled box frustum, small entries, full random, extreme
  // codes, perspective with w = -z, small entries again.
  task automatic load_random_matrix(input int kind);
    elem_t m [NUM_ELEMS];
    for (int i = 0; i < NUM_ELEMS; i++) begin
      case (kind)
        0, 4: m[i] = 0;
        1, 5: m[i] = $urandom_range(4 * ONE, 0) - 2 * ONE;
        2: m[i] = $urandom;
        default: begin
          case ($urandom_range(5, 0))
            0: m[i] = 32'h8000_0000;
            1: m[i] = 32'h7FFF_FFFF;
            2: m[i] = 0;
            3: m[i] = ONE;
            4: m[i] = -ONE;
            default: m[i] = $urandom;
          endcase
        end
      endcase
    end
    if (kind == 0 || kind == 4) begin
      m[0] = $urandom_range(2 * ONE, ONE / 4);
      m[5] = $urandom_range(2 * ONE, ONE / 4);
      m[10] = $urandom_range(2 * ONE, ONE / 4);
      m[12] = $urandom_range(ONE, 0) - ONE / 2;
      m[13] = $urandom_range(ONE, 0) - ONE / 2;
      m[14] = $urandom_range(ONE, 0) - ONE / 2;
      m[11] = (kind == 4) ? -ONE : 0;
      m[15] = (kind == 4) ? 0 : ONE;
    end
    load_matrix(m);
  endtask

  task automatic test_random_scenes();
    for (int scene = 0; scene < NUM_SCENES; scene++) begin
      load_random_matrix(scene);
      case (scene)
        0: begin send_gap_max = 19; take_stall_max = 19; end
        1: begin send_gap_max = 0;  take_stall_max = 0;  end
        2: begin send_gap_max = 0;  take_stall_max = 19; end
        3: begin send_gap_max = 19; take_stall_max = 0;  end
        4: begin send_gap_max = 4;  take_stall_max = 4;  end
        default: begin send_gap_max = 19; take_stall_max = 19; end
      endcase
      for (int n = 0; n < BOXES_PER_SCENE; n++) begin
        send_box(random_box());
        // hold the sender once per scene until the pipe runs dry
        if (n == BOXES_PER_SCENE / 2) wait_all_results();
      end
      wait_all_results();
    end
  endtask

  initial begin
    box_ch.valid = 1'b0;
    box_ch.min_x = '0;
    box_ch.min_y = '0;
    box_ch.min_z = '0;
    box_ch.max_x = '0;
    box_ch.max_y = '0;
    box_ch.max_z = '0;
    for (int i = 0; i < NUM_ELEMS; i++) view_proj[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_matrix();
    test_spare_index();
    test_identity_planes();
    test_zero_normal();
    test_extreme_matrix();
    test_random_scenes();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: stall a random number of cycles before taking each item.
  initial begin
    int stall;
    vis_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = $urandom_range(take_stall_max, 0);
      if (stall > 0) begin
        vis_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      vis_ch.ready <= 1'b1;
      do @(posedge clk); while (!(vis_ch.valid && vis_ch.ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && vis_ch.valid && vis_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected visibility item, expected none, actual %0b",
                 $time, vis_ch.visible);
        mismatch_count++;
      end else begin
        head_verdict = pending_verdicts.pop_front();
        if (vis_ch.visible !== head_verdict.visible) begin
          $display("%0t: visible mismatch for box %h, expected %0b, actual %0b",
                   $time, head_verdict.box, head_verdict.visible, vis_ch.visible);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((box_ch.valid && box_ch.ready) || (vis_ch.valid && vis_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/fac_pkg.sv
rtl/fac_ifs.sv
rtl/fac_plane_eval.sv
rtl/frustum_aabb_cull.sv
tb/frustum_aabb_cull_test.sv
